FILE: rtl/core/pur_pkg.sv
// shared types and codes for the picture unit register port
`timescale 1ns / 1ps

package pur_pkg;

    typedef logic [1:0] op_code_t;
    typedef logic [2:0] reg_sel_t;

    localparam op_code_t OP_READ   = 2'd0;
    localparam op_code_t OP_WRITE  = 2'd1;
    localparam op_code_t OP_VBLANK = 2'd2;

    localparam reg_sel_t REG_CTRL    = 3'd0;
    localparam reg_sel_t REG_MASK    = 3'd1;
    localparam reg_sel_t REG_STATUS  = 3'd2;
    localparam reg_sel_t REG_OAMADDR = 3'd3;
    localparam reg_sel_t REG_OAMDATA = 3'd4;
    localparam reg_sel_t REG_SCROLL  = 3'd5;
    localparam reg_sel_t REG_ADDR    = 3'd6;
    localparam reg_sel_t REG_DATA    = 3'd7;

    localparam logic [5:0] PALETTE_PAGE = 6'h3F;
    localparam int unsigned PALETTE_ENTRIES = 32;

    typedef enum logic [1:0]
    {
        KIND_NONE,
        KIND_STATUS,
        KIND_OAM_READ,
        KIND_DATA_READ
    } item_kind_t;

    typedef enum logic [1:0]
    {
        REGION_TILE,
        REGION_NAME,
        REGION_PALETTE
    } region_t;

    typedef struct packed
    {
        item_kind_t kind;
        region_t    region;
        logic       vblank;
        logic       nmi;
        logic [7:0] palette_data;
    } stage_info_t;

endpackage

FILE: rtl/core/pur_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module pur_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/picture_unit_register_port_core.sv
// picture unit cpu register port: registers, video memory decode and stores
`timescale 1ns / 1ps

// channel   | signals                          | contents
// s_axis    | tvalid tready tdata tuser        | tdata: write_data; tuser: operation, reg_select
// m_axis    | tvalid tready tdata              | tdata: read_data, nmi_request
// cfg       | cfg_we cfg_wdata                 | mirror_vertical
//
// an item is taken every cycle unless the second stage is stalled or the clearing pass runs;
// its result passes through the second stage and then the output register; register state and
// store writes settle at acceptance, store reads return registered in the next cycle; after reset
// a clearing pass zeroes the nametable and sprite stores over the larger of their two depths,
// during which no item is accepted; a stalled result holds the second stage and with it the input side

module picture_unit_register_port_core
#(
    parameter int SPRITE_RAM_BYTES = 256,
    parameter int NAME_BYTES       = 2048,
    parameter int TILE_BYTES       = 8192
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] write_data
    input  logic [4:0]  s_axis_tuser,   // [1:0] operation, [4:2] reg_select
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] read_data, [8] nmi_request, [15:9] zero
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    import pur_pkg::*;

    localparam int SPRITE_AW = $clog2(SPRITE_RAM_BYTES);
    localparam int NAME_AW   = $clog2(NAME_BYTES);
    localparam int TILE_AW   = $clog2(TILE_BYTES);
    localparam int CLR_DEPTH = (NAME_BYTES > SPRITE_RAM_BYTES) ? NAME_BYTES : SPRITE_RAM_BYTES;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);
    localparam logic [CLR_AW-1:0] CLR_LAST = CLR_AW'(CLR_DEPTH - 1);

    // configuration and register state
    logic        mirror_reg;
    logic [7:0]  control_reg, control_next;
    logic [7:0]  mask_reg, mask_next;
    logic        vblank_reg, vblank_next;
    logic        toggle_reg, toggle_next;
    logic [13:0] temp_addr_reg, temp_addr_next;
    logic [15:0] video_addr_reg, video_addr_next;
    logic [7:0]  scroll_x_reg, scroll_x_next;
    logic [7:0]  scroll_y_reg, scroll_y_next;
    logic [7:0]  sprite_addr_reg, sprite_addr_next;
    logic [7:0]  read_buffer_reg, read_buffer_next;
    logic [7:0]  colour_reg [PALETTE_ENTRIES];

    // clearing pass
    logic              clear_reg;
    logic [CLR_AW-1:0] clr_cnt_reg;

    // second stage and output register
    logic        b_valid_reg;
    stage_info_t b_info_reg, b_info_next;
    logic        out_valid_reg;
    logic [7:0]  out_rd_reg, out_rd_next;
    logic        out_nmi_reg;

    // item fields and decode
    op_code_t    op;
    reg_sel_t    sel;
    logic [7:0]  din;
    logic        accept;
    logic        b_advance;
    logic        is_write, is_read;
    logic [13:0] va;
    region_t     region;
    logic [4:0]  pal_idx;
    logic [4:0]  pal_rd_idx;
    logic        name_table;
    logic [NAME_AW-1:0]   name_idx;
    logic [TILE_AW-1:0]   tile_idx;
    logic [SPRITE_AW-1:0] sprite_idx;
    logic [15:0] video_step;

    // store ports
    logic                 sprite_we, name_we, tile_we, pal_we;
    logic [SPRITE_AW-1:0] sprite_waddr;
    logic [NAME_AW-1:0]   name_waddr;
    logic [7:0]           sprite_wdata, name_wdata;
    logic [7:0]           sprite_rdata, name_rdata, tile_rdata;
    logic [7:0]           fresh_byte;

    assign op  = op_code_t'(s_axis_tuser[1:0]);
    assign sel = reg_sel_t'(s_axis_tuser[4:2]);
    assign din = s_axis_tdata;

    assign b_advance     = b_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clear_reg && (!b_valid_reg || b_advance);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_write      = (op == OP_WRITE);
    assign is_read       = (op == OP_READ);

    assign va         = video_addr_reg[13:0];
    assign pal_idx    = va[4:0];
    assign pal_rd_idx = (pal_idx[1:0] == 2'b00) ? 5'd0 : pal_idx;
    assign name_table = mirror_reg ? va[10] : va[11];
    assign name_idx   = NAME_AW'({name_table, va[9:0]});
    assign tile_idx   = TILE_AW'(va[12:0]);
    assign sprite_idx = SPRITE_AW'(sprite_addr_reg);
    assign video_step = control_reg[2] ? 16'd32 : 16'd1;

    always_comb
    begin
        if (va[13:8] == PALETTE_PAGE)
        begin
            region = REGION_PALETTE;
        end
        else if (va[13])
        begin
            region = REGION_NAME;
        end
        else
        begin
            region = REGION_TILE;
        end
    end

    // store writes happen at acceptance, the clearing pass owns the sprite and nametable ports after reset
    always_comb
    begin
        sprite_we    = accept && is_write && (sel == REG_OAMDATA);
        sprite_waddr = sprite_idx;
        sprite_wdata = din;
        name_we      = accept && is_write && (sel == REG_DATA) && (region == REGION_NAME);
        name_waddr   = name_idx;
        name_wdata   = din;
        tile_we      = accept && is_write && (sel == REG_DATA) && (region == REGION_TILE);
        pal_we       = accept && is_write && (sel == REG_DATA) && (region == REGION_PALETTE);
        if (clear_reg)
        begin
            sprite_we    = 1'b1;
            sprite_waddr = clr_cnt_reg[SPRITE_AW-1:0];
            sprite_wdata = 8'h00;
            name_we      = 1'b1;
            name_waddr   = clr_cnt_reg[NAME_AW-1:0];
            name_wdata   = 8'h00;
        end
    end

    pur_ram
    #(
        .WIDTH (8),
        .DEPTH (SPRITE_RAM_BYTES)
    )
    u_sprite_ram
    (
        .clk   (clk),
        .we    (sprite_we),
        .waddr (sprite_waddr),
        .wdata (sprite_wdata),
        .re    (accept),
        .raddr (sprite_idx),
        .rdata (sprite_rdata)
    );

    pur_ram
    #(
        .WIDTH (8),
        .DEPTH (NAME_BYTES)
    )
    u_name_ram
    (
        .clk   (clk),
        .we    (name_we),
        .waddr (name_waddr),
        .wdata (name_wdata),
        .re    (accept),
        .raddr (name_idx),
        .rdata (name_rdata)
    );

    pur_ram
    #(
        .WIDTH (8),
        .DEPTH (TILE_BYTES)
    )
    u_tile_ram
    (
        .clk   (clk),
        .we    (tile_we),
        .waddr (tile_idx),
        .wdata (din),
        .re    (accept),
        .raddr (tile_idx),
        .rdata (tile_rdata)
    );

    // register updates at acceptance
    always_comb
    begin
        control_next     = control_reg;
        mask_next        = mask_reg;
        vblank_next      = vblank_reg;
        toggle_next      = toggle_reg;
        temp_addr_next   = temp_addr_reg;
        video_addr_next  = video_addr_reg;
        scroll_x_next    = scroll_x_reg;
        scroll_y_next    = scroll_y_reg;
        sprite_addr_next = sprite_addr_reg;
        b_info_next.kind         = KIND_NONE;
        b_info_next.region       = region;
        b_info_next.vblank       = vblank_reg;
        b_info_next.nmi          = 1'b0;
        b_info_next.palette_data = colour_reg[pal_rd_idx];
        if (accept)
        begin
            if (is_read)
            begin
                unique case (sel)
                    REG_STATUS:
                    begin
                        b_info_next.kind = KIND_STATUS;
                        vblank_next      = 1'b0;
                        toggle_next      = 1'b0;
                    end
                    REG_OAMDATA:
                    begin
                        b_info_next.kind = KIND_OAM_READ;
                    end
                    REG_DATA:
                    begin
                        b_info_next.kind = KIND_DATA_READ;
                        video_addr_next  = video_addr_reg + video_step;
                    end
                    default:
                    begin
                        b_info_next.kind = KIND_NONE;
                    end
                endcase
            end
            else if (is_write)
            begin
                unique case (sel)
                    REG_CTRL:
                    begin
                        control_next          = din;
                        temp_addr_next[11:10] = din[1:0];
                    end
                    REG_MASK:
                    begin
                        mask_next = din;
                    end
                    REG_OAMADDR:
                    begin
                        sprite_addr_next = din;
                    end
                    REG_OAMDATA:
                    begin
                        sprite_addr_next = sprite_addr_reg + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        if (toggle_reg)
                        begin
                            scroll_y_next = din;
                        end
                        else
                        begin
                            scroll_x_next = din;
                        end
                        toggle_next = !toggle_reg;
                    end
                    REG_ADDR:
                    begin
                        if (!toggle_reg)
                        begin
                            temp_addr_next[13:8] = din[5:0];
                        end
                        else
                        begin
                            temp_addr_next[7:0] = din;
                            video_addr_next     = {2'b00, temp_addr_reg[13:8], din};
                        end
                        toggle_next = !toggle_reg;
                    end
                    REG_DATA:
                    begin
                        video_addr_next = video_addr_reg + video_step;
                    end
                    default:
                    begin
                        control_next = control_reg;
                    end
                endcase
            end
            else if (op == OP_VBLANK)
            begin
                vblank_next     = 1'b1;
                b_info_next.nmi = control_reg[7];
            end
        end
    end

    // second stage: store data has arrived
    always_comb
    begin
        unique case (b_info_reg.region)
            REGION_PALETTE: fresh_byte = b_info_reg.palette_data;
            REGION_NAME:    fresh_byte = name_rdata;
            default:        fresh_byte = tile_rdata;
        endcase
        read_buffer_next = read_buffer_reg;
        out_rd_next      = 8'h00;
        unique case (b_info_reg.kind)
            KIND_STATUS:
            begin
                out_rd_next = {b_info_reg.vblank, 2'b00, read_buffer_reg[4:0]};
            end
            KIND_OAM_READ:
            begin
                out_rd_next = sprite_rdata;
            end
            KIND_DATA_READ:
            begin
                out_rd_next = (b_info_reg.region == REGION_PALETTE) ? fresh_byte
                                                                    : read_buffer_reg;
                read_buffer_next = fresh_byte;
            end
            default:
            begin
                out_rd_next = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg      <= 1'b0;
            control_reg     <= 8'h00;
            mask_reg        <= 8'h00;
            vblank_reg      <= 1'b0;
            toggle_reg      <= 1'b0;
            temp_addr_reg   <= 14'h0000;
            video_addr_reg  <= 16'h0000;
            scroll_x_reg    <= 8'h00;
            scroll_y_reg    <= 8'h00;
            sprite_addr_reg <= 8'h00;
            read_buffer_reg <= 8'h00;
            clear_reg       <= 1'b1;
            clr_cnt_reg     <= '0;
            b_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < PALETTE_ENTRIES; i++)
            begin
                colour_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                mirror_reg <= cfg_wdata;
            end
            control_reg     <= control_next;
            mask_reg        <= mask_next;
            vblank_reg      <= vblank_next;
            toggle_reg      <= toggle_next;
            temp_addr_reg   <= temp_addr_next;
            video_addr_reg  <= video_addr_next;
            scroll_x_reg    <= scroll_x_next;
            scroll_y_reg    <= scroll_y_next;
            sprite_addr_reg <= sprite_addr_next;
            // backdrop indices also land in entry zero
            if (pal_we)
            begin
                for (int i = 0; i < PALETTE_ENTRIES; i++)
                begin
                    if ((5'(i) == pal_idx) || ((i == 0) && (pal_idx[1:0] == 2'b00)))
                    begin
                        colour_reg[i] <= din;
                    end
                end
            end
            if (clear_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                begin
                    clear_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_advance)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_advance)
            begin
                read_buffer_reg <= read_buffer_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_info_reg <= b_info_next;
        end
        if (b_advance)
        begin
            out_rd_reg  <= out_rd_next;
            out_nmi_reg <= b_info_reg.nmi;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0000000, out_nmi_reg, out_rd_reg};

`ifndef SYNTH
    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !s_axis_tready)
        else $error("item taken during clearing pass");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(b_valid_reg))
        else $error("result without an item in the second stage");

    a_vblank_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == OP_VBLANK) |=> vblank_reg)
        else $error("vblank event did not set the flag");

    a_one_store_written: assert property (@(posedge clk) disable iff (!rst_n)
        !clear_reg |-> $onehot0({tile_we, name_we, pal_we, sprite_we}))
        else $error("more than one store written by one item");

    a_clear_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clear_reg) |-> $past(clr_cnt_reg) == CLR_LAST)
        else $error("clearing pass ended early");
`endif

endmodule
